FILE: rtl/efx_pkg.sv
// ----------------------------------------------------------------------------
// Escaped frame transmitter package
// Shared types, register indexes and the byte escaping helper.
// ----------------------------------------------------------------------------
package efx_pkg;

  // Longest run of line bytes that one request can cause.
  localparam int unsigned RUN_MAX = 10;
  localparam int unsigned CNT_W   = $clog2(RUN_MAX + 1);
  localparam int unsigned POS_W   = $clog2(RUN_MAX);
  localparam int unsigned NUM_SYM = 6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [1:0] CFG_END_BYTE    = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd2;
  localparam logic [1:0] CFG_ESCAPE_MASK = 2'd3;

  // Request kinds.
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
    logic [7:0] escape_mask;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  frame_type;
    logic [15:0] payload_len;
    logic [7:0]  payload_byte;
  } req_t;

  typedef struct packed {
    logic        frame_open;
    logic [15:0] bytes_left;
    logic [7:0]  running_xor;
  } frame_state_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
  } run_t;

  // One logical byte of a frame before it is stuffed.
  typedef struct packed {
    logic       present;
    logic       escapable;
    logic [7:0] value;
  } sym_t;

  // True when a byte collides with one of the special values.
  function automatic logic needs_escape(input logic [7:0] b, input cfg_t cfg);
    needs_escape = (b == cfg.escape_byte) || (b == cfg.start_byte) ||
                   (b == cfg.end_byte);
  endfunction

endpackage

FILE: rtl/efx_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying start and payload requests.
// ----------------------------------------------------------------------------
interface efx_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  frame_type;
  logic [15:0] payload_len;
  logic [7:0]  payload_byte;

  modport source (output valid, req_type, frame_type, payload_len, payload_byte,
                  input ready);
  modport sink   (input valid, req_type, frame_type, payload_len, payload_byte,
                  output ready);
  modport monitor (input valid, ready, req_type, frame_type, payload_len,
                   payload_byte);
endinterface

// ----------------------------------------------------------------------------
// Line byte channel
// Valid/ready channel carrying stuffed line bytes.
// ----------------------------------------------------------------------------
interface efx_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       run_last;

  modport source  (output valid, tx_byte, run_last, input ready);
  modport sink    (input valid, tx_byte, run_last, output ready);
  modport monitor (input valid, ready, tx_byte, run_last);
endinterface

FILE: rtl/efx_encoder.sv
// ----------------------------------------------------------------------------
// Escaped frame encoder
// Builds the stuffed byte run for one request and the next frame state.
// ----------------------------------------------------------------------------
module efx_encoder (
  input  efx_pkg::req_t         req_i,
  input  efx_pkg::frame_state_t state_i,
  input  efx_pkg::cfg_t         cfg_i,
  output efx_pkg::run_t         run_o,
  output efx_pkg::frame_state_t state_o
);
  import efx_pkg::*;

  sym_t [NUM_SYM-1:0] sym;
  logic [15:0]        left_dec;
  logic [7:0]         xor_next;
  logic               len_zero;
  logic               closes;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   pos_nxt;

  assign left_dec = state_i.bytes_left - 16'd1;
  assign xor_next = state_i.running_xor ^ req_i.payload_byte;
  assign len_zero = (req_i.payload_len == 16'd0);
  assign closes   = (left_dec == 16'd0);

  // Logical byte sequence and state update.
  always_comb begin
    sym     = '0;
    state_o = state_i;
    case (req_i.req_type)
      REQ_START: begin
        sym[0] = '{present: 1'b1, escapable: 1'b0, value: cfg_i.start_byte};
        sym[1] = '{present: 1'b1, escapable: 1'b1, value: req_i.frame_type};
        sym[2] = '{present: 1'b1, escapable: 1'b1, value: req_i.payload_len[15:8]};
        sym[3] = '{present: 1'b1, escapable: 1'b1, value: req_i.payload_len[7:0]};
        sym[4] = '{present: len_zero, escapable: 1'b1, value: 8'h00};
        sym[5] = '{present: len_zero, escapable: 1'b0, value: cfg_i.end_byte};
        state_o.frame_open  = !len_zero;
        state_o.bytes_left  = req_i.payload_len;
        state_o.running_xor = 8'h00;
      end
      REQ_PAYLOAD: begin
        if (state_i.frame_open) begin
          sym[0] = '{present: 1'b1, escapable: 1'b1, value: req_i.payload_byte};
          sym[1] = '{present: closes, escapable: 1'b1, value: xor_next};
          sym[2] = '{present: closes, escapable: 1'b0, value: cfg_i.end_byte};
          if (closes) begin
            state_o = '0;
          end else begin
            state_o.bytes_left  = left_dec;
            state_o.running_xor = xor_next;
          end
        end
      end
      default: begin
        sym = '0;
      end
    endcase
  end

  // Stuff the logical bytes into consecutive run positions.
  always_comb begin
    run_o   = '0;
    pos     = '0;
    pos_nxt = '0;
    for (int i = 0; i < NUM_SYM; i++) begin
      pos_nxt = pos + CNT_W'(1);
      if (sym[i].present) begin
        if (sym[i].escapable && needs_escape(sym[i].value, cfg_i)) begin
          run_o.bytes[pos[POS_W-1:0]]     = cfg_i.escape_byte;
          run_o.bytes[pos_nxt[POS_W-1:0]] = sym[i].value ^ cfg_i.escape_mask;
          pos = pos + CNT_W'(2);
        end else begin
          run_o.bytes[pos[POS_W-1:0]] = sym[i].value;
          pos = pos_nxt;
        end
      end
    end
    run_o.count = pos;
  end

endmodule

FILE: rtl/efx_serializer.sv
// ----------------------------------------------------------------------------
// Run serializer
// Holds one stuffed byte run and hands it out a byte per transaction.
// ----------------------------------------------------------------------------
module efx_serializer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  efx_pkg::run_t run_i,
  output logic          load_ready_o,
  efx_tx_if.source      tx
);
  import efx_pkg::*;

  logic [RUN_MAX-1:0][7:0] bytes_q, bytes_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    pop;

  assign pop          = tx.valid && tx.ready;
  assign load_ready_o = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && tx.ready);

  assign tx.valid    = (cnt_q != '0);
  assign tx.tx_byte  = bytes_q[0];
  assign tx.run_last = (cnt_q == CNT_W'(1));

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      bytes_d = run_i.bytes;
      cnt_d   = run_i.count;
    end else if (pop) begin
      bytes_d = {8'h00, bytes_q[RUN_MAX-1:1]};
      cnt_d   = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

FILE: rtl/escaped_frame_transmitter.sv
// ----------------------------------------------------------------------------
// Escaped frame transmitter
// Byte-stuffing framer with an XOR checksum over the payload.
// ----------------------------------------------------------------------------
// Each request transaction produces a run of zero to ten line bytes on the tx
// channel, one byte per transaction, with run_last set on the final byte of
// the run. A start request sends the start byte, then the stuffed frame type
// and payload length (high byte first); a zero length also closes the frame
// at once with checksum zero and the end byte. Each payload request sends its
// stuffed byte, and the one that completes the frame adds the stuffed XOR
// checksum and the end byte. Payload with no open frame yields nothing, and a
// start request abandons any open frame. A request is registered, encoded
// combinationally and handed as a whole run to the output serializer, which
// sends one line byte per cycle while tx is ready. The serializer's single
// output port sets the rate; a dropped payload byte leaves the input register
// without waiting for it, and the next request is taken while the previous
// run is still draining. Configuration registers may be written only while
// the block is idle.
// ----------------------------------------------------------------------------
module escaped_frame_transmitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  efx_req_if.sink    req,
  efx_tx_if.source   tx
);
  import efx_pkg::*;

  cfg_t         cfg_q, cfg_d;
  frame_state_t state_q, state_next;
  req_t         req_q;
  logic         req_vld_q;
  run_t         run;
  logic         load_ready;
  logic         advance;

  // Configuration registers. Writes are taken at any time but the block must
  // be idle for the new values to apply cleanly.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_BYTE:  cfg_d.start_byte  = cfg_data_i;
        CFG_END_BYTE:    cfg_d.end_byte    = cfg_data_i;
        CFG_ESCAPE_BYTE: cfg_d.escape_byte = cfg_data_i;
        CFG_ESCAPE_MASK: cfg_d.escape_mask = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // The input register moves on when its run fits in the serializer; a
  // request that yields no bytes never waits for the serializer.
  assign advance   = req_vld_q && ((run.count == '0) || load_ready);
  assign req.ready = !req_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '{start_byte: 8'd123, end_byte: 8'd125,
                     escape_byte: 8'd92, escape_mask: 8'd32};
      state_q   <= '0;
      req_vld_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (advance) begin
        state_q <= state_next;
      end
      if (req.ready) begin
        req_vld_q <= req.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      req_q <= '{req_type: req.req_type, frame_type: req.frame_type,
                 payload_len: req.payload_len, payload_byte: req.payload_byte};
    end
  end

  efx_encoder u_encoder (
    .req_i   (req_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .run_o   (run),
    .state_o (state_next)
  );

  efx_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && (run.count != '0)),
    .run_i        (run),
    .load_ready_o (load_ready),
    .tx           (tx)
  );

endmodule

FILE: rtl/efx_checker.sv
// ----------------------------------------------------------------------------
// Escaped frame transmitter checker
// Port-level assertions on the line byte channel, bound to the top level.
// ----------------------------------------------------------------------------
module efx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tx_valid_i,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       run_last_i
);

  // A byte offered on the line stays offered until it is taken.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_i && !tx_ready_i) |=> tx_valid_i)
    else $error("tx valid dropped before the transaction completed");

  // A stalled byte keeps its value and its end-of-run marker.
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_i && !tx_ready_i) |=> ($stable(tx_byte_i) && $stable(run_last_i)))
    else $error("tx payload changed while stalled");

  // A run is never cut short: after a byte that is not the last, more follow.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_i && tx_ready_i && !run_last_i) |=> tx_valid_i)
    else $error("run ended without a byte marked as last");

  // Nothing is offered straight out of reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !tx_valid_i)
    else $error("tx valid high straight after reset");

endmodule

bind escaped_frame_transmitter efx_checker u_efx_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .tx_valid_i (tx.valid),
  .tx_ready_i (tx.ready),
  .tx_byte_i  (tx.tx_byte),
  .run_last_i (tx.run_last)
);

FILE: tb/escaped_frame_transmitter_tb.sv
// ----------------------------------------------------------------------------
// Escaped frame transmitter testbench
// Drives start and payload requests into the framer and compares every line
// byte with a cycle-free model of the byte stuffing and XOR checksum. Several
// delimiter settings are used, the link side idles and stalls at random, and
// one long receiver hold-off forces the framer to back up its request channel.
// ----------------------------------------------------------------------------
module escaped_frame_transmitter_tb;
  import efx_pkg::*;

  // Cycles allowed after the last line byte before the verdict or a register
  // write; a dropped payload byte only lingers in the input register.
  localparam int unsigned DRAIN_CYCLES = 12;
  // Length of the receiver hold-off used to fill the framer up.
  localparam int unsigned HOLD_CYCLES  = 300;
  // Items sent per random phase; eight phases give at least 304 in total.
  localparam int unsigned PHASE_ITEMS  = 38;
  localparam int unsigned NUM_PHASES   = 8;
  // Hard stop for the whole run, in time units.
  localparam int unsigned RUN_LIMIT    = 6_000_000;

  // One stuffed byte on the serial line together with its end-of-run flag.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
  } line_byte_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the frame state and register settings of the framer
  // and keeps the line bytes that accepted requests are still owed.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    cfg_t         cfg;
    frame_state_t st;
    line_byte_t   pending[$];
    int unsigned  errors;

    function new();
      cfg    = '{8'd123, 8'd125, 8'd92, 8'd32};
      st     = '0;
      errors = 0;
    endfunction

    function void push_raw(logic [7:0] b);
      pending.push_back('{b, 1'b0});
    endfunction

    // A byte that collides with any delimiter or the escape value goes out as
    // the escape value followed by the byte under the mask.
    function void push_stuffed(logic [7:0] b);
      if (b == cfg.escape_byte || b == cfg.start_byte || b == cfg.end_byte) begin
        push_raw(cfg.escape_byte);
        push_raw(b ^ cfg.escape_mask);
      end else begin
        push_raw(b);
      end
    endfunction

    function void close_frame();
      push_stuffed(st.running_xor);
      push_raw(cfg.end_byte);
      st = '0;
    endfunction

    // Called for every accepted request transaction.
    function void predict_request(req_t r);
      if (r.req_type == REQ_START) begin
        st.running_xor = 8'h00;
        st.bytes_left  = r.payload_len;
        st.frame_open  = (r.payload_len != 16'd0);
        push_raw(cfg.start_byte);
        push_stuffed(r.frame_type);
        push_stuffed(r.payload_len[15:8]);
        push_stuffed(r.payload_len[7:0]);
        if (r.payload_len == 16'd0) close_frame();
      end else begin
        if (!st.frame_open) return;
        push_stuffed(r.payload_byte);
        st.running_xor = st.running_xor ^ r.payload_byte;
        st.bytes_left  = st.bytes_left - 16'd1;
        if (st.bytes_left == 16'd0) close_frame();
      end
      pending[$].run_last = 1'b1;
    endfunction

    // Called for every accepted line byte transaction.
    function void check_line_byte(logic [7:0] b, logic last);
      line_byte_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected line byte: expected none, got %02h (run_last %0b)",
                 $time, b, last);
        return;
      end
      want = pending.pop_front();
      if (b !== want.tx_byte) begin
        errors++;
        $display("%0t: tx_byte mismatch: expected %02h, got %02h",
                 $time, want.tx_byte, b);
      end
      if (last !== want.run_last) begin
        errors++;
        $display("%0t: run_last mismatch on byte %02h: expected %0b, got %0b",
                 $time, want.tx_byte, want.run_last, last);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  efx_req_if req_ch();
  efx_tx_if  tx_ch();

  escaped_frame_transmitter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .tx         (tx_ch)
  );

  frame_scoreboard board;

  // Traffic shaping switches, set by the stimulus process.
  bit src_calm;
  bit rx_calm;
  bit hold_armed;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Both channels are observed at the rising edge, where a transaction takes
  // place. The request is noted before the line byte is checked, although a
  // request can never produce a byte at the edge on which it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        board.predict_request({req_ch.req_type, req_ch.frame_type,
                               req_ch.payload_len, req_ch.payload_byte});
      end
      if (tx_ch.valid && tx_ch.ready) begin
        board.check_line_byte(tx_ch.tx_byte, tx_ch.run_last);
      end
    end
  end

  // The serial link side. It drops ready at random with a chance of twelve
  // percent, never while calm, and when a hold-off is armed it counts out a long
  // stretch with ready low so that the framer fills up behind it.
  initial begin : line_sink
    int unsigned hold_left;
    hold_left   = 0;
    tx_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        tx_ch.ready <= 1'b0;
        hold_left--;
      end else if (rx_calm) begin
        tx_ch.ready <= 1'b1;
      end else begin
        tx_ch.ready <= ($urandom_range(99) >= 12);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT);
    $display("escaped_frame_transmitter_tb NOT OK");
    $finish;
  end

  function automatic req_t mk_req(logic kind, logic [7:0] ftype, logic [15:0] len,
                                  logic [7:0] pbyte);
    req_t r;
    r.req_type     = kind;
    r.frame_type   = ftype;
    r.payload_len  = len;
    r.payload_byte = pbyte;
    return r;
  endfunction

  // One of the values that the current settings force into an escape.
  function automatic logic [7:0] pick_special();
    case ($urandom_range(2))
      0:       return board.cfg.start_byte;
      1:       return board.cfg.end_byte;
      default: return board.cfg.escape_byte;
    endcase
  endfunction

  // Biased towards the escaped values so that stuffing happens often.
  function automatic logic [7:0] pick_value();
    if ($urandom_range(99) < 30) return pick_special();
    return 8'($urandom_range(255));
  endfunction

  // Offers one request, with an optional idle gap in front, and returns at the
  // falling edge after the transaction. Valid is left high so that the next
  // request can follow back to back; the caller's next step lowers it.
  task automatic send_req(input req_t r);
    int unsigned gap;
    gap = 0;
    if (!src_calm) begin
      while ($urandom_range(99) < 12) gap++;
    end
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.req_type;
    req_ch.frame_type   <= r.frame_type;
    req_ch.payload_len  <= r.payload_len;
    req_ch.payload_byte <= r.payload_byte;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // Lowers valid, waits for every owed line byte and lets the framer settle.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes all four registers, one per cycle; only called while idle.
  task automatic apply_config(input cfg_t c);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_START_BYTE;
    cfg_data_i <= c.start_byte;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_END_BYTE;
    cfg_data_i <= c.end_byte;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_ESCAPE_BYTE;
    cfg_data_i <= c.escape_byte;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_ESCAPE_MASK;
    cfg_data_i <= c.escape_mask;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    board.cfg = c;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.start_byte  = 8'($urandom_range(255));
    c.end_byte    = ($urandom_range(3) == 0) ? c.start_byte : 8'($urandom_range(255));
    c.escape_byte = 8'($urandom_range(255));
    c.escape_mask = 8'($urandom_range(255));
    return c;
  endfunction

  // Mostly well-formed frames with random content. Some frames are cut short
  // by the next start, some are followed by a stray byte, and a share of the
  // traffic is plain noise. Payload bytes with no open frame are not counted.
  task automatic run_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned n_bytes;
    int unsigned roll;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        if ($urandom_range(1) == 0) begin
          if (board.st.frame_open) sent++;
          send_req(mk_req(REQ_PAYLOAD, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), pick_value()));
        end else begin
          send_req(mk_req(REQ_START, pick_value(), 16'($urandom_range(65535)),
                          8'($urandom_range(255))));
          sent++;
        end
      end else begin
        roll = $urandom_range(99);
        if (roll < 10)      len = 0;
        else if (roll < 80) len = $urandom_range(1, 6);
        else if (roll < 95) len = $urandom_range(7, 20);
        else                len = {pick_value(), pick_value()};
        send_req(mk_req(REQ_START, pick_value(), 16'(len), 8'($urandom_range(255))));
        sent++;
        n_bytes = (len > 20) ? $urandom_range(0, 4) : len;
        // Now and then the frame is abandoned part way through.
        if (len != 0 && n_bytes == len && $urandom_range(9) == 0) begin
          n_bytes = $urandom_range(0, len - 1);
        end
        for (int unsigned k = 0; k < n_bytes; k++) begin
          // Steer the checksum onto an escaped value now and then.
          if (k + 1 == len && $urandom_range(3) == 0) b = board.st.running_xor ^ pick_special();
          else                                        b = pick_value();
          send_req(mk_req(REQ_PAYLOAD, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), b));
          sent++;
        end
        // A stray byte after the frame must be dropped if the frame is closed.
        if ($urandom_range(9) == 0) begin
          if (board.st.frame_open) sent++;
          send_req(mk_req(REQ_PAYLOAD, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), pick_value()));
        end
      end
    end
  endtask

  initial begin : stimulus
    cfg_t c;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_START_BYTE;
    cfg_data_i          = 8'h00;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_START;
    req_ch.frame_type   = 8'h00;
    req_ch.payload_len  = 16'h0000;
    req_ch.payload_byte = 8'h00;
    src_calm            = 1'b0;
    rx_calm             = 1'b0;
    hold_armed          = 1'b0;
    board = new();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset settings: start 7B, end 7D, escape 5C.
    // A payload byte before any frame is dropped.
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'hFF));
    // A zero-length frame closes at once with checksum zero.
    send_req(mk_req(REQ_START,   8'h00, 16'h0000, 8'h00));
    // Escaped frame type, then end and escape values as payload.
    send_req(mk_req(REQ_START,   8'h7B, 16'h0002, 8'h00));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'h7D));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'h5C));
    // The frame is closed, so this byte is dropped.
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'hA5));
    // Largest length; the frame is then abandoned by a new start.
    send_req(mk_req(REQ_START,   8'hFF, 16'hFFFF, 8'h00));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'h00));
    // Both length bytes escaped, also abandoned.
    send_req(mk_req(REQ_START,   8'h5C, 16'h7B7D, 8'h00));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'hFF));
    send_req(mk_req(REQ_START,   8'h7D, 16'h5C00, 8'hFF));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'h01));
    // Checksum equal to the start byte.
    send_req(mk_req(REQ_START,   8'h01, 16'h0002, 8'h00));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'h03));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'h78));
    // Checksum equal to the escape byte.
    send_req(mk_req(REQ_START,   8'h80, 16'h0001, 8'h00));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'h5C));
    // Extreme payload bytes.
    send_req(mk_req(REQ_START,   8'h7F, 16'h0003, 8'h00));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'h00));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'hFF));
    send_req(mk_req(REQ_PAYLOAD, 8'h00, 16'h0000, 8'h7D));

    // Random phases, each under its own register setting. Extremes come
    // first: all-zero delimiters give the longest run of ten bytes on a
    // zero-length frame, and all-ones delimiters collide with one another.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0:       c = '{8'h00, 8'hFF, 8'h80, 8'hFF};
        1:       c = '{8'h00, 8'h00, 8'h00, 8'h00};
        2:       c = '{8'hFF, 8'hFF, 8'hFF, 8'h01};
        5:       c = '{8'h7E, 8'h7E, 8'h7D, 8'h20};
        7:       c = '{8'd123, 8'd125, 8'd92, 8'd32};
        default: c = random_config();
      endcase
      apply_config(c);
      // Phase 2 runs with no idling on either side; phase 4 holds the link
      // off while the requests keep coming, so the input backs up.
      src_calm = (p == 2) || (p == 4);
      rx_calm  = (p == 2);
      if (p == 4) hold_armed = 1'b1;
      run_frames(PHASE_ITEMS);
    end

    wait_drained();
    if (board.pending.size() != 0) begin
      $display("%0t: %0d line bytes still expected at the end",
               $time, board.pending.size());
    end
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("escaped_frame_transmitter_tb OK");
    end else begin
      $display("escaped_frame_transmitter_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: escaped_frame_transmitter.f
rtl/efx_pkg.sv
rtl/efx_req_if.sv
rtl/efx_encoder.sv
rtl/efx_serializer.sv
rtl/escaped_frame_transmitter.sv
rtl/efx_checker.sv
tb/escaped_frame_transmitter_tb.sv
